### sv/threshold_partition_descending_sort_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the threshold partition sort store
// Implication and never-true checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_PARTITION_DESCENDING_SORT_ASSERT_SVH
`define THRESHOLD_PARTITION_DESCENDING_SORT_ASSERT_SVH
`ifndef ASSERT_OFF
// ante holding at an edge demands cons at the same edge
`define TPDS_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tpds: implication check failed");
// cond must never hold at an edge
`define TPDS_ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("tpds: forbidden condition seen");
`else
`define TPDS_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define TPDS_ASSERT_NEVER(lbl, ck, rn, cond)
`endif
`endif

### sv/tpds_pkg.sv
// ----------------------------------------------------------------------------
// tpds_pkg
// Shared widths, codes and sequencer states of the threshold partition sort.
// ----------------------------------------------------------------------------
package tpds_pkg;

	localparam int unsigned CAPACITY_DEF = 1024;
	localparam int unsigned SCORE_W      = 32;
	localparam int unsigned MOVE_W       = 32;
	localparam int unsigned KEY_W        = SCORE_W + MOVE_W;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_READ = 1'b1
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PART,
		ST_SORT_PASS,
		ST_RUN_INIT,
		ST_RUN_RA,
		ST_RUN_RB,
		ST_MERGE,
		ST_RD_ISSUE,
		ST_RD_DATA
	} state_t;

	// score half of a key against the limit, both signed
	function automatic logic meets_limit(input logic [KEY_W-1:0] key,
			input logic signed [SCORE_W-1:0] lim);
		return $signed(key[KEY_W-1 -: SCORE_W]) >= lim;
	endfunction

endpackage

### sv/tpds_in_if.sv
// ----------------------------------------------------------------------------
// tpds_in_if
// Request channel: load or read command with the entry to load.
// ----------------------------------------------------------------------------
interface tpds_in_if;
	logic                                      valid;
	logic                                      ready;
	logic                                      func;
	logic signed [tpds_pkg::SCORE_W-1:0]      score_in;
	logic        [tpds_pkg::MOVE_W-1:0]       move_in;

	modport source (output valid, func, score_in, move_in, input ready);
	modport sink   (input valid, func, score_in, move_in, output ready);
endinterface

### sv/tpds_out_if.sv
// ----------------------------------------------------------------------------
// tpds_out_if
// Response channel: one ordered entry, or an empty marker.
// ----------------------------------------------------------------------------
interface tpds_out_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [tpds_pkg::SCORE_W-1:0]      score_out;
	logic        [tpds_pkg::MOVE_W-1:0]       move_out;
	logic                                      above_limit;
	logic                                      empty_res;
	logic                                      last;

	modport source (output valid, score_out, move_out, above_limit, empty_res, last,
		input ready);
	modport sink   (input valid, score_out, move_out, above_limit, empty_res, last,
		output ready);
endinterface

### sv/threshold_partition_descending_sort.sv
// ----------------------------------------------------------------------------
// threshold_partition_descending_sort
// Entry store that returns entries scoring at or above a limit first, in
// descending 64-bit key order, then the remaining entries in arrival order.
// ----------------------------------------------------------------------------
//
//  channel   | kind          | transfer moves
//  ----------+---------------+-----------------------------------------------
//  req       | valid/ready   | func, score_in, move_in (load or read command)
//  rsp       | valid/ready   | score_out, move_out, above_limit, empty_res, last
//  cfg       | write enable  | score_limit (cfg_data), no read-back
//
//  A load is taken in ST_IDLE, which the sequencer keeps; a read of an ordered
//  list passes ST_RD_ISSUE and ST_RD_DATA (ST_RD_ISSUE alone once the list is
//  exhausted) and may wait in ST_RD_ISSUE for the response register to drain.
//  The first read after loads orders the list: two partition sweeps over
//  bank 0, then a bottom-up merge sort of the h leading entries on one 64-bit
//  comparator over ceil(log2 h) passes, ping-ponging between the two RAM banks.
//  Reset clears only control state; the RAM needs no clearing pass.
//  The request side is held off while ordering or reading; loads are still
//  taken while a response waits to be transferred.
//
// ----------------------------------------------------------------------------
`include "threshold_partition_descending_sort_assert.svh"

module threshold_partition_descending_sort #(
	parameter int unsigned CAPACITY = tpds_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tpds_pkg::SCORE_W-1:0]       cfg_data,
	tpds_in_if.sink                            req,
	tpds_out_if.source                         rsp
);

	localparam int unsigned AW = $clog2(CAPACITY);  // RAM address
	localparam int unsigned CW = AW + 1;            // counts up to CAPACITY
	localparam int unsigned SW = CW + 1;            // headroom for run bounds
	localparam int unsigned KW = tpds_pkg::KEY_W;
	localparam int unsigned SCW = tpds_pkg::SCORE_W;
	localparam int unsigned MW = tpds_pkg::MOVE_W;

	// ---------------------------------------------------------------- state
	tpds_pkg::state_t state_q, state_d;

	logic [CW-1:0] cnt_q, cnt_d;         // entries in the current list
	logic [CW-1:0] rpos_q, rpos_d;       // next entry to give
	logic          ordered_q, ordered_d;
	logic signed [SCW-1:0] limit_q;

	// partition sweeps
	logic [CW-1:0] ptr_q, ptr_d;         // bank 0 read pointer
	logic          rv_s1, rv_d;          // bank 0 read data valid
	logic          pass2_q, pass2_d;     // second sweep collects the rest
	logic [CW-1:0] wp_q, wp_d;           // bank 1 write pointer
	logic [CW-1:0] hi_q, hi_d;           // size of the leading group

	// merge sequencer
	logic [CW-1:0] w_q, w_d;             // run width of this pass
	logic [CW-1:0] lo_q, lo_d;           // start of the run pair
	logic [CW-1:0] pos_a_q, pos_a_d, end_a_q, end_a_d;
	logic [CW-1:0] pos_b_q, pos_b_d, end_b_q, end_b_d;
	logic [CW-1:0] dst_q, dst_d;
	logic          va_q, va_d, vb_q, vb_d;          // run head present
	logic          pend_a_q, pend_a_d, pend_b_q, pend_b_d; // head arriving from RAM
	logic          src_q, src_d;         // bank holding the sorted group
	logic [KW-1:0] ha_q, ha_d, hb_q, hb_d;
	logic          rbank_q, rbank_d;     // bank read for a response

	// response register
	logic                  out_vld_q, out_vld_d;
	logic                  out_load;
	logic signed [SCW-1:0] out_score_q, out_score_d;
	logic [MW-1:0]         out_move_q, out_move_d;
	logic                  out_above_q, out_above_d;
	logic                  out_empty_q, out_empty_d;
	logic                  out_last_q, out_last_d;
	logic                  out_zero;

	// RAM banks: bank 0 takes loads, banks 1 and 0 alternate while merging
	logic          ram_we [2];
	logic [AW-1:0] ram_wa [2];
	logic [KW-1:0] ram_wd [2];
	logic [AW-1:0] ram_ra [2];
	logic [KW-1:0] ram_rd [2];

	for (genvar g = 0; g < 2; g++) begin : g_bank
		tpds_ram #(
			.WIDTH (KW),
			.DEPTH (CAPACITY)
		) u_ram (
			.clk   (clk),
			.we    (ram_we[g]),
			.waddr (ram_wa[g]),
			.wdata (ram_wd[g]),
			.raddr (ram_ra[g]),
			.rdata (ram_rd[g])
		);
	end

	// ------------------------------------------------------- merge datapath
	logic [KW-1:0] src_rd;
	logic [KW-1:0] a_eff, b_eff;
	logic          take_a;
	logic [SW-1:0] mid_sum, top_sum, next_lo;

	assign src_rd  = ram_rd[src_q];
	// forward a head straight from the RAM in the cycle it arrives
	assign a_eff   = pend_a_q ? src_rd : ha_q;
	assign b_eff   = pend_b_q ? src_rd : hb_q;
	assign take_a  = va_q && (!vb_q || ($signed(a_eff) >= $signed(b_eff)));
	assign mid_sum = SW'(lo_q) + SW'(w_q);
	assign top_sum = SW'(lo_q) + (SW'(w_q) << 1);
	assign next_lo = top_sum;

	assign req.ready = (state_q == tpds_pkg::ST_IDLE);

	// ------------------------------------------------------- sequencer
	always_comb begin
		logic [KW-1:0] pkey;
		logic [KW-1:0] rkey;
		logic          bank;

		state_d   = state_q;
		cnt_d     = cnt_q;
		rpos_d    = rpos_q;
		ordered_d = ordered_q;
		ptr_d     = ptr_q;
		rv_d      = 1'b0;
		pass2_d   = pass2_q;
		wp_d      = wp_q;
		hi_d      = hi_q;
		w_d       = w_q;
		lo_d      = lo_q;
		pos_a_d   = pos_a_q;
		end_a_d   = end_a_q;
		pos_b_d   = pos_b_q;
		end_b_d   = end_b_q;
		dst_d     = dst_q;
		va_d      = va_q;
		vb_d      = vb_q;
		pend_a_d  = 1'b0;
		pend_b_d  = 1'b0;
		src_d     = src_q;
		rbank_d   = rbank_q;
		ha_d      = a_eff;
		hb_d      = b_eff;

		out_vld_d   = out_vld_q && !rsp.ready;
		out_load    = 1'b0;
		out_score_d = out_score_q;
		out_move_d  = out_move_q;
		out_above_d = out_above_q;
		out_empty_d = out_empty_q;
		out_last_d  = out_last_q;

		for (int b = 0; b < 2; b++) begin
			ram_we[b] = 1'b0;
			ram_wa[b] = '0;
			ram_wd[b] = '0;
			ram_ra[b] = '0;
		end

		pkey = ram_rd[0];
		rkey = ram_rd[rbank_q];
		bank = 1'b1;

		unique case (state_q)
			tpds_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (req.func == tpds_pkg::FUNC_LOAD) begin
						ram_wd[0] = {req.score_in, req.move_in};
						if (ordered_q) begin
							// a load after reads opens a new list
							ram_we[0] = 1'b1;
							ram_wa[0] = '0;
							cnt_d     = CW'(1);
							rpos_d    = '0;
							ordered_d = 1'b0;
						end else if (cnt_q < CW'(CAPACITY)) begin
							ram_we[0] = 1'b1;
							ram_wa[0] = cnt_q[AW-1:0];
							cnt_d     = cnt_q + CW'(1);
						end
					end else if (ordered_q) begin
						state_d = tpds_pkg::ST_RD_ISSUE;
					end else begin
						ptr_d   = '0;
						pass2_d = 1'b0;
						wp_d    = '0;
						state_d = tpds_pkg::ST_PART;
					end
				end
			end

			tpds_pkg::ST_PART: begin
				if (ptr_q < cnt_q) begin
					ram_ra[0] = ptr_q[AW-1:0];
					ptr_d     = ptr_q + CW'(1);
					rv_d      = 1'b1;
				end
				if (rv_s1 && (tpds_pkg::meets_limit(pkey, limit_q) != pass2_q)) begin
					ram_we[1] = 1'b1;
					ram_wa[1] = wp_q[AW-1:0];
					ram_wd[1] = pkey;
					wp_d      = wp_q + CW'(1);
				end
				if (ptr_q >= cnt_q && !rv_s1) begin
					if (!pass2_q) begin
						pass2_d = 1'b1;
						ptr_d   = '0;
						hi_d    = wp_q;
					end else begin
						w_d     = CW'(1);
						src_d   = 1'b1;
						state_d = tpds_pkg::ST_SORT_PASS;
					end
				end
			end

			tpds_pkg::ST_SORT_PASS: begin
				if (w_q >= hi_q) begin
					ordered_d = 1'b1;
					rpos_d    = '0;
					state_d   = tpds_pkg::ST_RD_ISSUE;
				end else begin
					lo_d    = '0;
					dst_d   = '0;
					state_d = tpds_pkg::ST_RUN_INIT;
				end
			end

			tpds_pkg::ST_RUN_INIT: begin
				pos_a_d = lo_q;
				end_a_d = (mid_sum >= SW'(hi_q)) ? hi_q : mid_sum[CW-1:0];
				pos_b_d = (mid_sum >= SW'(hi_q)) ? hi_q : mid_sum[CW-1:0];
				end_b_d = (top_sum >= SW'(hi_q)) ? hi_q : top_sum[CW-1:0];
				state_d = tpds_pkg::ST_RUN_RA;
			end

			tpds_pkg::ST_RUN_RA: begin
				ram_ra[src_q] = pos_a_q[AW-1:0];
				pos_a_d       = pos_a_q + CW'(1);
				va_d          = 1'b1;
				pend_a_d      = 1'b1;
				state_d       = tpds_pkg::ST_RUN_RB;
			end

			tpds_pkg::ST_RUN_RB: begin
				if (pos_b_q < end_b_q) begin
					ram_ra[src_q] = pos_b_q[AW-1:0];
					pos_b_d       = pos_b_q + CW'(1);
					vb_d          = 1'b1;
					pend_b_d      = 1'b1;
				end else begin
					vb_d = 1'b0;
				end
				state_d = tpds_pkg::ST_MERGE;
			end

			tpds_pkg::ST_MERGE: begin
				if (!va_q && !vb_q) begin
					if (next_lo >= SW'(hi_q)) begin
						src_d   = ~src_q;
						w_d     = w_q << 1;
						state_d = tpds_pkg::ST_SORT_PASS;
					end else begin
						lo_d    = next_lo[CW-1:0];
						state_d = tpds_pkg::ST_RUN_INIT;
					end
				end else begin
					ram_we[~src_q] = 1'b1;
					ram_wa[~src_q] = dst_q[AW-1:0];
					ram_wd[~src_q] = take_a ? a_eff : b_eff;
					dst_d          = dst_q + CW'(1);
					if (take_a) begin
						if (pos_a_q < end_a_q) begin
							ram_ra[src_q] = pos_a_q[AW-1:0];
							pos_a_d       = pos_a_q + CW'(1);
							pend_a_d      = 1'b1;
						end else begin
							va_d = 1'b0;
						end
					end else begin
						if (pos_b_q < end_b_q) begin
							ram_ra[src_q] = pos_b_q[AW-1:0];
							pos_b_d       = pos_b_q + CW'(1);
							pend_b_d      = 1'b1;
						end else begin
							vb_d = 1'b0;
						end
					end
				end
			end

			tpds_pkg::ST_RD_ISSUE: begin
				// wait until the response register is free next cycle
				if (!out_vld_q || rsp.ready) begin
					if (rpos_q >= cnt_q) begin
						out_vld_d   = 1'b1;
						out_load    = 1'b1;
						out_score_d = '0;
						out_move_d  = '0;
						out_above_d = 1'b0;
						out_empty_d = 1'b1;
						out_last_d  = 1'b0;
						state_d     = tpds_pkg::ST_IDLE;
					end else begin
						// sorted group sits in src, the rest stays in bank 1
						bank         = (rpos_q < hi_q) ? src_q : 1'b1;
						ram_ra[bank] = rpos_q[AW-1:0];
						rbank_d      = bank;
						rpos_d       = rpos_q + CW'(1);
						state_d      = tpds_pkg::ST_RD_DATA;
					end
				end
			end

			tpds_pkg::ST_RD_DATA: begin
				out_vld_d   = 1'b1;
				out_load    = 1'b1;
				out_score_d = rkey[KW-1 -: SCW];
				out_move_d  = rkey[MW-1:0];
				out_above_d = tpds_pkg::meets_limit(rkey, limit_q);
				out_empty_d = 1'b0;
				out_last_d  = (rpos_q == cnt_q);
				state_d     = tpds_pkg::ST_IDLE;
			end

			default: begin
				state_d = tpds_pkg::ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tpds_pkg::ST_IDLE;
			cnt_q     <= '0;
			rpos_q    <= '0;
			ordered_q <= 1'b0;
			limit_q   <= '0;
			ptr_q     <= '0;
			rv_s1     <= 1'b0;
			pass2_q   <= 1'b0;
			wp_q      <= '0;
			hi_q      <= '0;
			w_q       <= '0;
			lo_q      <= '0;
			pos_a_q   <= '0;
			end_a_q   <= '0;
			pos_b_q   <= '0;
			end_b_q   <= '0;
			dst_q     <= '0;
			va_q      <= 1'b0;
			vb_q      <= 1'b0;
			pend_a_q  <= 1'b0;
			pend_b_q  <= 1'b0;
			src_q     <= 1'b1;
			rbank_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			rpos_q    <= rpos_d;
			ordered_q <= ordered_d;
			if (cfg_we) begin
				limit_q <= $signed(cfg_data);
			end
			ptr_q     <= ptr_d;
			rv_s1     <= rv_d;
			pass2_q   <= pass2_d;
			wp_q      <= wp_d;
			hi_q      <= hi_d;
			w_q       <= w_d;
			lo_q      <= lo_d;
			pos_a_q   <= pos_a_d;
			end_a_q   <= end_a_d;
			pos_b_q   <= pos_b_d;
			end_b_q   <= end_b_d;
			dst_q     <= dst_d;
			va_q      <= va_d;
			vb_q      <= vb_d;
			pend_a_q  <= pend_a_d;
			pend_b_q  <= pend_b_d;
			src_q     <= src_d;
			rbank_q   <= rbank_d;
			out_vld_q <= out_vld_d;
		end
	end

	// ------------------------------------------------------- payload registers
	always_ff @(posedge clk) begin
		ha_q <= ha_d;
		hb_q <= hb_d;
		if (out_load) begin
			out_score_q <= out_score_d;
			out_move_q  <= out_move_d;
			out_above_q <= out_above_d;
			out_empty_q <= out_empty_d;
			out_last_q  <= out_last_d;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.score_out   = out_score_q;
	assign rsp.move_out    = out_move_q;
	assign rsp.above_limit = out_above_q;
	assign rsp.empty_res   = out_empty_q;
	assign rsp.last        = out_last_q;

	// every field but the empty marker cleared
	assign out_zero = (out_score_q == '0) && (out_move_q == '0) && !out_above_q && !out_last_q;

	// ------------------------------------------------------- assertions
	`TPDS_ASSERT_IMPLY(a_empty_zero, clk, arst_n, out_vld_q && out_empty_q, out_zero)
	`TPDS_ASSERT_NEVER(a_count_cap, clk, arst_n, cnt_q > CW'(CAPACITY))
	`TPDS_ASSERT_NEVER(a_rpos_cnt, clk, arst_n, rpos_q > cnt_q)
	`TPDS_ASSERT_NEVER(a_one_fetch, clk, arst_n, pend_a_q && pend_b_q)
	`TPDS_ASSERT_IMPLY(a_hi_cnt, clk, arst_n, ordered_q, hi_q <= cnt_q)

endmodule

### sv/tpds_ram.sv
// ----------------------------------------------------------------------------
// tpds_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tpds_ram #(
	parameter int unsigned WIDTH = tpds_pkg::KEY_W,
	parameter int unsigned DEPTH = tpds_pkg::CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### tb/tb_threshold_partition_descending_sort.sv
// ----------------------------------------------------------------------------
// tb_threshold_partition_descending_sort
// Self-checking bench for the threshold partition sort store: a directed
// table, then random lists of loads and reads under several idle/stall mixes.
// Every response transfer is checked field by field against its expected entry:
// the table's own for typed rows, else that of an in-bench model of the store.
// ----------------------------------------------------------------------------
module tb_threshold_partition_descending_sort;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW             = tpds_pkg::SCORE_W;
	localparam int MW             = tpds_pkg::MOVE_W;
	localparam int KW             = tpds_pkg::KEY_W;
	localparam int CAP            = tpds_pkg::CAPACITY_DEF;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int SETTLE         = 12;   // cycles a read may still need after its response
	localparam int PHASE_ITEMS    = 60;
	localparam int HOLD_CYCLES    = 400;
	localparam int OVERFILL_READS = 224;

	// one expected response transfer
	typedef struct packed {
		logic signed [SW-1:0] score;
		logic        [MW-1:0] move;
		logic                 above_limit;
		logic                 empty_res;
		logic                 last;
	} sort_result_t;

	// one row of the directed table; typed rows carry their own expectation
	typedef struct {
		tpds_pkg::func_t      func;
		logic signed [SW-1:0] score;
		logic        [MW-1:0] move;
		bit                   typed;
		sort_result_t         want;
	} directed_row_t;

	// one random phase: limit, sender idle and receiver stall odds in percent, squeeze flag
	typedef struct {
		logic signed [SW-1:0] limit;
		int                   idle;
		int                   stall;
		bit                   squeeze;
	} phase_t;

	localparam sort_result_t NO_ENTRY =
		'{score: '0, move: '0, above_limit: 1'b0, empty_res: 1'b1, last: 1'b0};
	localparam sort_result_t NOTHING = '0;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [SW-1:0] cfg_data;

	tpds_in_if  req_if ();
	tpds_out_if rsp_if ();

	threshold_partition_descending_sort uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	// ------------------------------------------------------------------
	// Model of the ordering store
	// ------------------------------------------------------------------
	logic [KW-1:0]        held_keys [CAP];
	int                   held_count;
	int                   read_at;
	bit                   list_ordered;
	logic signed [SW-1:0] limit_now;

	sort_result_t pending_entries [$];   // responses still owed by the block

	int fail_count;
	int issued;
	int idle_pct;
	int stall_pct;
	int hold_len;
	int hold_seq;
	int cycle_count;

	logic signed [SW-1:0] recent_score;
	logic        [MW-1:0] recent_move;

	// The directed table: the read of an empty store, key extremes, ties on
	// score broken by the move word, the list running out, and a load after
	// reads (whole or partial) starting a fresh list. Limit is 0 here.
	directed_row_t step_table [20] = '{
		'{tpds_pkg::FUNC_READ, 32'sh0,        32'h0,        1'b1, NO_ENTRY},
		'{tpds_pkg::FUNC_LOAD, 32'sh7FFFFFFF, 32'hFFFFFFFF, 1'b0, NOTHING},
		'{tpds_pkg::FUNC_LOAD, 32'sh80000000, 32'h00000000, 1'b0, NOTHING},
		'{tpds_pkg::FUNC_LOAD, 32'sh0,        32'h00000000, 1'b0, NOTHING},
		'{tpds_pkg::FUNC_LOAD, 32'shFFFFFFFF, 32'h80000000, 1'b0, NOTHING},
		'{tpds_pkg::FUNC_LOAD, 32'sh0,        32'hFFFFFFFF, 1'b0, NOTHING},
		'{tpds_pkg::FUNC_READ, 32'sh0,        32'h0,        1'b1,
			'{score: 32'sh7FFFFFFF, move: 32'hFFFFFFFF, above_limit: 1'b1,
				empty_res: 1'b0, last: 1'b0}},
		'{tpds_pkg::FUNC_READ, 32'sh0,        32'h0,        1'b0, NOTHING},
		'{tpds_pkg::FUNC_READ, 32'sh0,        32'h0,        1'b0, NOTHING},
		'{tpds_pkg::FUNC_READ, 32'sh0,        32'h0,        1'b0, NOTHING},
		'{tpds_pkg::FUNC_READ, 32'sh0,        32'h0,        1'b0, NOTHING},
		'{tpds_pkg::FUNC_READ, 32'sh0,        32'h0,        1'b1, NO_ENTRY},
		'{tpds_pkg::FUNC_LOAD, 32'sh5,        32'h1,        1'b0, NOTHING},
		'{tpds_pkg::FUNC_READ, 32'sh0,        32'h0,        1'b1,
			'{score: 32'sh5, move: 32'h1, above_limit: 1'b1, empty_res: 1'b0,
				last: 1'b1}},
		'{tpds_pkg::FUNC_READ, 32'sh0,        32'h0,        1'b1, NO_ENTRY},
		'{tpds_pkg::FUNC_LOAD, 32'sh80000000, 32'hFFFFFFFF, 1'b0, NOTHING},
		'{tpds_pkg::FUNC_LOAD, 32'sh7FFFFFFF, 32'h00000000, 1'b0, NOTHING},
		'{tpds_pkg::FUNC_READ, 32'sh0,        32'h0,        1'b0, NOTHING},
		'{tpds_pkg::FUNC_LOAD, 32'sh1,        32'h1,        1'b0, NOTHING},
		'{tpds_pkg::FUNC_READ, 32'sh0,        32'h0,        1'b1,
			'{score: 32'sh1, move: 32'h1, above_limit: 1'b1, empty_res: 1'b0,
				last: 1'b1}}
	};

	function automatic bit at_or_above(input logic [KW-1:0] key);
		return $signed(key[KW-1 -: SW]) >= limit_now;
	endfunction

	// Put the entries at or above the limit first, in descending signed key
	// order; keep the rest behind them in arrival order.
	function automatic void arrange_held();
		logic [KW-1:0] lead [$];
		logic [KW-1:0] rest [$];
		logic [KW-1:0] cur;
		int j;
		for (int i = 0; i < held_count; i++) begin
			if (at_or_above(held_keys[i]))
				lead.push_back(held_keys[i]);
			else
				rest.push_back(held_keys[i]);
		end
		for (int i = 1; i < lead.size(); i++) begin
			cur = lead[i];
			j = i;
			while (j > 0 && $signed(lead[j-1]) < $signed(cur)) begin
				lead[j] = lead[j-1];
				j--;
			end
			lead[j] = cur;
		end
		foreach (lead[i])
			held_keys[i] = lead[i];
		foreach (rest[i])
			held_keys[lead.size() + i] = rest[i];
	endfunction

	// Advance the model by one accepted request; returns 1 when a response is owed.
	function automatic bit predict_sort_step(input tpds_pkg::func_t f,
			input logic signed [SW-1:0] s, input logic [MW-1:0] m,
			output sort_result_t r);
		logic [KW-1:0] key;
		r = '0;
		if (f == tpds_pkg::FUNC_LOAD) begin
			// a load after any read discards the old list
			if (list_ordered) begin
				held_count   = 0;
				read_at      = 0;
				list_ordered = 1'b0;
			end
			// beyond capacity the load is dropped
			if (held_count < CAP) begin
				held_keys[held_count] = {s, m};
				held_count++;
			end
			return 1'b0;
		end
		if (!list_ordered) begin
			arrange_held();
			list_ordered = 1'b1;
			read_at      = 0;
		end
		if (read_at >= held_count) begin
			r.empty_res = 1'b1;
			return 1'b1;
		end
		key = held_keys[read_at];
		read_at++;
		r.score       = key[KW-1 -: SW];
		r.move        = key[MW-1:0];
		r.above_limit = at_or_above(key);   // always against the limit in force now
		r.last        = (read_at == held_count);
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Clock, reset and the cycle limit
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Response side: ready pattern, with a long hold-off on request
	// ------------------------------------------------------------------
	initial begin : rsp_drive
		int seen;
		int left;
		seen = 0;
		left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seq != seen) begin
				seen = hold_seq;
				left = hold_len;
			end
			if (left > 0) begin
				rsp_if.ready = 1'b0;
				left--;
			end else begin
				rsp_if.ready = ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Check each response transfer against the oldest owed entry.
	always @(posedge clk) begin : rsp_check
		sort_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_entries.size() == 0) begin
				$error("response transfer with nothing owed: score %0h move %0h empty %0b",
					rsp_if.score_out, rsp_if.move_out, rsp_if.empty_res);
				fail_count++;
			end else begin
				want = pending_entries.pop_front();
				compare_field("score_out",   want.score,       rsp_if.score_out);
				compare_field("move_out",    want.move,        rsp_if.move_out);
				compare_field("above_limit", want.above_limit, rsp_if.above_limit);
				compare_field("empty_res",   want.empty_res,   rsp_if.empty_res);
				compare_field("last",        want.last,        rsp_if.last);
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offer one request from a falling edge; return at the falling edge after
	// its transfer. Typed rows owe their own expectation, others the model's.
	task automatic offer(input tpds_pkg::func_t f, input logic signed [SW-1:0] s,
			input logic [MW-1:0] m, input bit typed, input sort_result_t typed_res);
		sort_result_t owed;
		while ($urandom_range(0, 99) < idle_pct) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid    = 1'b1;
		req_if.func     = f;
		req_if.score_in = s;
		req_if.move_in  = m;
		do
			@(posedge clk);
		while (!req_if.ready);
		if (predict_sort_step(f, s, m, owed))
			pending_entries.push_back(typed ? typed_res : owed);
		issued++;
		@(negedge clk);
	endtask

	function automatic logic signed [SW-1:0] draw_score();
		logic signed [SW-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'sh7FFFFFFF;
			1: v = 32'sh80000000;
			2: v = limit_now;
			3: v = limit_now - 1;
			4: v = limit_now + 1;
			5: v = int'($urandom_range(0, 16)) - 8;
			6: v = recent_score;            // repeat, so the move word decides
			default: v = $urandom;
		endcase
		recent_score = v;
		return v;
	endfunction

	function automatic logic [MW-1:0] draw_move();
		logic [MW-1:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = recent_move;
			3: v = $urandom_range(0, 3);
			default: v = $urandom;
		endcase
		recent_move = v;
		return v;
	endfunction

	// Load n entries, then issue the given number of reads.
	task automatic play_list(input int n, input int reads);
		for (int i = 0; i < n; i++)
			offer(tpds_pkg::FUNC_LOAD, draw_score(), draw_move(), 1'b0, NOTHING);
		for (int i = 0; i < reads; i++)
			offer(tpds_pkg::FUNC_READ, $urandom, $urandom, 1'b0, NOTHING);
	endtask

	// Drop valid, wait for every owed response, then let the block settle.
	task automatic quiesce();
		req_if.valid = 1'b0;
		while (pending_entries.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write the limit while the block is idle; return at a falling edge.
	task automatic write_limit(input logic signed [SW-1:0] v);
		cfg_we   = 1'b1;
		cfg_data = v;
		@(posedge clk);
		limit_now = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly well-formed lists with random content, some noise, some partial
	// reads, and now and then a pause until every response has come back.
	task automatic random_traffic(input int quota);
		int start;
		int n;
		int reads;
		int pick;
		start = issued;
		while (issued - start < quota) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				repeat ($urandom_range(1, 4))
					offer(tpds_pkg::func_t'($urandom_range(0, 1)), draw_score(),
						draw_move(), 1'b0, NOTHING);
			end else if (pick == 1) begin
				quiesce();
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100)
					: $urandom_range(0, 20);
				reads = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n)
					: n + $urandom_range(0, 2);
				play_list(n, reads);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		phase_t phases [8];

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_data        = '0;
		req_if.valid    = 1'b0;
		req_if.func     = tpds_pkg::FUNC_LOAD;
		req_if.score_in = '0;
		req_if.move_in  = '0;
		idle_pct        = 0;
		stall_pct       = 0;
		hold_len        = 0;
		hold_seq        = 0;
		fail_count      = 0;
		issued          = 0;
		held_count      = 0;
		read_at         = 0;
		list_ordered    = 1'b0;
		limit_now       = '0;
		recent_score    = '0;
		recent_move     = '0;

		// limit extremes, zero, values near zero and anything at all
		phases[0] = '{32'sh0,        0,  0,  1'b0};
		phases[1] = '{32'sh80000000, 76, 0,  1'b0};
		phases[2] = '{32'sh7FFFFFFF, 0,  76, 1'b0};
		phases[3] = '{$urandom,      16, 16, 1'b0};
		phases[4] = '{int'($urandom_range(0, 40)) - 20, 0, 0, 1'b0};
		phases[5] = '{$urandom,      76, 0,  1'b0};
		phases[6] = '{-32'sd1,       0,  76, 1'b1};
		phases[7] = '{$urandom,      16, 16, 1'b0};

		// hold reset, then release it away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table at full rate
		foreach (step_table[i])
			offer(step_table[i].func, step_table[i].score, step_table[i].move,
				step_table[i].typed, step_table[i].want);

		foreach (phases[p]) begin
			// leave a list half read so the new limit meets an ordered list
			play_list(6, 3);
			quiesce();
			write_limit(phases[p].limit);
			idle_pct  = phases[p].idle;
			stall_pct = phases[p].stall;
			play_list(0, 4);

			if (phases[p].squeeze) begin
				// hold the response side off while loads and reads keep coming,
				// so the block fills and stalls its request side
				hold_len = HOLD_CYCLES;
				hold_seq++;
				play_list(10, 10);
			end
			random_traffic(PHASE_ITEMS);
		end

		// overfill the store: loads past capacity are dropped, then read the
		// head of the order
		quiesce();
		write_limit($urandom);
		idle_pct  = 16;
		stall_pct = 16;
		play_list(CAP + $urandom_range(1, 5), OVERFILL_READS);

		quiesce();
		repeat (40) @(posedge clk);

		if (fail_count == 0 && pending_entries.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
